### rtl/core/pun_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pun_pkg
// Types, register indexes and fixed-point helpers for the undistortion core.
// ----------------------------------------------------------------------------
package pun_pkg;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_P1       = 3'd6,
    REG_P2       = 3'd7
  } reg_idx_t;

  localparam logic [23:0] FOCAL_RST    = 24'd128000;
  localparam logic [23:0] CENTER_X_RST = 24'd81920;
  localparam logic [23:0] CENTER_Y_RST = 24'd61440;
  localparam int unsigned DIV_STEPS    = 31;

  localparam logic signed [51:0] S48_HI = {5'b00000, {47{1'b1}}};
  localparam logic signed [51:0] S48_LO = {5'b11111, {47{1'b0}}};
  localparam logic signed [51:0] S32_HI = {21'd0, {31{1'b1}}};
  localparam logic signed [51:0] S32_LO = {{21{1'b1}}, {31{1'b0}}};
  localparam logic [48:0] MAG48_MAX     = {2'b00, {47{1'b1}}};
  localparam logic [47:0] HH_LIMIT      = 48'd134217728;

  // one point as it moves down the pipeline
  typedef struct packed {
    logic               vld;
    logic               last;
    logic signed [31:0] xd;
    logic signed [31:0] yd;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pun_item_t;

  // partial products of one q.28 multiply
  typedef struct packed {
    logic [47:0] hh;
    logic [47:0] hl;
    logic [47:0] lh;
    logic [47:0] ll;
    logic        neg;
  } pp_t;

  // one axis of the normalizing divider
  typedef struct packed {
    logic [23:0] rem;
    logic [30:0] q;
    logic [2:0]  sh;
    logic        neg;
    logic        zero;
    logic        sat;
  } div_t;

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [51:0] r;
    r = v;
    if (v > S48_HI) r = S48_HI;
    if (v < S48_LO) r = S48_LO;
    return r[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [51:0] r;
    r = v;
    if (v > S32_HI) r = S32_HI;
    if (v < S32_LO) r = S32_LO;
    return r[31:0];
  endfunction

  function automatic pp_t mul_pp(input logic signed [47:0] a, input logic signed [47:0] b);
    logic [47:0] ua;
    logic [47:0] ub;
    pp_t p;
    ua = a[47] ? (~a + 48'd1) : a;
    ub = b[47] ? (~b + 48'd1) : b;
    p.hh = ua[47:24] * ub[47:24];
    p.hl = ua[47:24] * ub[23:0];
    p.lh = ua[23:0] * ub[47:24];
    p.ll = ua[23:0] * ub[23:0];
    p.neg = a[47] ^ b[47];
    return p;
  endfunction

  function automatic logic signed [47:0] mul_fin(input pp_t p);
    logic [49:0] t;
    logic [48:0] q;
    logic signed [47:0] mag;
    t = 50'(p.hl) + 50'(p.lh) + 50'(p.ll >> 24);
    if (p.hh >= HH_LIMIT) begin
      q = MAG48_MAX;
    end else begin
      q = {2'b00, p.hh[26:0], 20'd0} + 49'(t >> 4);
      if (q > MAG48_MAX) q = MAG48_MAX;
    end
    mag = $signed(q[47:0]);
    return p.neg ? -mag : mag;
  endfunction

  function automatic div_t div_init(input logic [23:0] pix, input logic [23:0] ctr,
                                    input logic [23:0] f);
    logic signed [24:0] d;
    logic [24:0] m;
    div_t s;
    d = $signed({1'b0, pix}) - $signed({1'b0, ctr});
    m = d[24] ? (~d + 25'd1) : d;
    s.neg = d[24];
    s.zero = (m[23:0] == 24'd0);
    s.sat = !s.zero && ({3'b000, m[23:0]} >= {f, 3'b000});
    s.rem = {3'b000, m[23:3]};
    s.sh = m[2:0];
    s.q = '0;
    return s;
  endfunction

  function automatic div_t div_step(input div_t s, input logic [23:0] f);
    logic [24:0] r2;
    div_t n;
    n = s;
    r2 = {s.rem, s.sh[2]};
    n.sh = {s.sh[1:0], 1'b0};
    if (r2 >= {1'b0, f}) begin
      r2 = r2 - {1'b0, f};
      n.q = {s.q[29:0], 1'b1};
    end else begin
      n.q = {s.q[29:0], 1'b0};
    end
    n.rem = r2[23:0];
    return n;
  endfunction

  function automatic logic signed [31:0] div_out(input div_t s);
    logic signed [31:0] r;
    if (s.zero) r = '0;
    else if (s.sat) r = s.neg ? S32_LO[31:0] : S32_HI[31:0];
    else r = s.neg ? -$signed({1'b0, s.q}) : $signed({1'b0, s.q});
    return r;
  endfunction

endpackage

### rtl/core/pun_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pun_norm
// Pixel to distorted normalized coordinate: offset, then a one bit per stage
// divide by the focal length on both axes.
// ----------------------------------------------------------------------------
module pun_norm
  import pun_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [23:0] pix_x,
  input  logic [23:0] pix_y,
  input  logic        last,
  input  logic [23:0] focal_x,
  input  logic [23:0] focal_y,
  input  logic [23:0] center_x,
  input  logic [23:0] center_y,
  output pun_item_t   item_o
);

  div_t      dx_r   [0:DIV_STEPS];
  div_t      dy_r   [0:DIV_STEPS];
  logic      vld_r  [0:DIV_STEPS];
  logic      last_r [0:DIV_STEPS];
  pun_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= in_vld;
    dx_r[0] <= div_init(pix_x, center_x, focal_x);
    dy_r[0] <= div_init(pix_y, center_y, focal_y);
    last_r[0] <= last;
  end

  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else vld_r[s] <= vld_r[s-1];
      dx_r[s] <= div_step(dx_r[s-1], focal_x);
      dy_r[s] <= div_step(dy_r[s-1], focal_y);
      last_r[s] <= last_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) item_r.vld <= 1'b0;
    else item_r.vld <= vld_r[DIV_STEPS];
    item_r.last <= last_r[DIV_STEPS];
    item_r.xd <= div_out(dx_r[DIV_STEPS]);
    item_r.yd <= div_out(dy_r[DIV_STEPS]);
    item_r.x <= div_out(dx_r[DIV_STEPS]);
    item_r.y <= div_out(dy_r[DIV_STEPS]);
  end

  assign item_o = item_r;

endmodule

### rtl/core/pun_pass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pun_pass
// One fixed-point undistortion pass, twelve register stages.
// ----------------------------------------------------------------------------
module pun_pass
  import pun_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] k1,
  input  logic signed [31:0] k2,
  input  logic signed [31:0] p1,
  input  logic signed [31:0] p2,
  input  pun_item_t          item_i,
  output pun_item_t          item_o
);

  pun_item_t it_r [1:12];

  pp_t pxx_r, pyy_r, pxy_r;
  logic signed [47:0] x2_r, y2_r, xy_r;
  logic signed [47:0] r2_r, x2b_r, y2b_r, xy3_r;
  pp_t prr_r, pkr_r;
  logic signed [47:0] sx_r, sy_r, xy4_r;
  logic signed [47:0] rr_r, kr_r, sx5_r, sy5_r, xy5_r;
  pp_t pk2_r, pa1_r, pa2_r, pb1_r, pb2_r;
  logic signed [47:0] kr6_r;
  logic signed [47:0] k2rr_r, a1_r, a2_r, b1_r, b2_r, kr7_r;
  logic signed [47:0] rad_r;
  logic signed [49:0] partx_r, party_r;
  pp_t pxr_r, pyr_r;
  logic signed [49:0] partx9_r, party9_r;
  logic signed [47:0] xr_r, yr_r;
  logic signed [49:0] partx10_r, party10_r;
  logic signed [47:0] dx_r, dy_r;
  logic signed [31:0] xo_r, yo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 12; i++) it_r[i].vld <= 1'b0;
    end else begin
      it_r[1].vld <= item_i.vld;
      for (int i = 2; i <= 12; i++) it_r[i].vld <= it_r[i-1].vld;
    end
    it_r[1].last <= item_i.last;
    it_r[1].xd <= item_i.xd;
    it_r[1].yd <= item_i.yd;
    it_r[1].x <= item_i.x;
    it_r[1].y <= item_i.y;
    for (int i = 2; i <= 12; i++) begin
      it_r[i].last <= it_r[i-1].last;
      it_r[i].xd <= it_r[i-1].xd;
      it_r[i].yd <= it_r[i-1].yd;
      it_r[i].x <= it_r[i-1].x;
      it_r[i].y <= it_r[i-1].y;
    end

    // squares and cross term
    pxx_r <= mul_pp(48'(item_i.x), 48'(item_i.x));
    pyy_r <= mul_pp(48'(item_i.y), 48'(item_i.y));
    pxy_r <= mul_pp(48'(item_i.x), 48'(item_i.y));
    x2_r <= mul_fin(pxx_r);
    y2_r <= mul_fin(pyy_r);
    xy_r <= mul_fin(pxy_r);
    r2_r <= sat48(52'(x2_r) + 52'(y2_r));
    x2b_r <= x2_r;
    y2b_r <= y2_r;
    xy3_r <= xy_r;

    // radial terms and tangential sums
    prr_r <= mul_pp(r2_r, r2_r);
    pkr_r <= mul_pp(48'(k1), r2_r);
    sx_r <= sat48(52'(r2_r) + 52'(x2b_r) + 52'(x2b_r));
    sy_r <= sat48(52'(r2_r) + 52'(y2b_r) + 52'(y2b_r));
    xy4_r <= xy3_r;
    rr_r <= mul_fin(prr_r);
    kr_r <= mul_fin(pkr_r);
    sx5_r <= sx_r;
    sy5_r <= sy_r;
    xy5_r <= xy4_r;

    pk2_r <= mul_pp(48'(k2), rr_r);
    pa1_r <= mul_pp(48'(p1), xy5_r);
    pa2_r <= mul_pp(48'(p2), sx5_r);
    pb1_r <= mul_pp(48'(p2), xy5_r);
    pb2_r <= mul_pp(48'(p1), sy5_r);
    kr6_r <= kr_r;
    k2rr_r <= mul_fin(pk2_r);
    a1_r <= mul_fin(pa1_r);
    a2_r <= mul_fin(pa2_r);
    b1_r <= mul_fin(pb1_r);
    b2_r <= mul_fin(pb2_r);
    kr7_r <= kr6_r;

    rad_r <= sat48(52'(kr7_r) + 52'(k2rr_r));
    partx_r <= 50'(a1_r) + 50'(a1_r) + 50'(a2_r);
    party_r <= 50'(b1_r) + 50'(b1_r) + 50'(b2_r);

    pxr_r <= mul_pp(48'(it_r[8].x), rad_r);
    pyr_r <= mul_pp(48'(it_r[8].y), rad_r);
    partx9_r <= partx_r;
    party9_r <= party_r;
    xr_r <= mul_fin(pxr_r);
    yr_r <= mul_fin(pyr_r);
    partx10_r <= partx9_r;
    party10_r <= party9_r;

    dx_r <= sat48(52'(xr_r) + 52'(partx10_r));
    dy_r <= sat48(52'(yr_r) + 52'(party10_r));

    xo_r <= sat32(52'(it_r[11].xd) - 52'(dx_r));
    yo_r <= sat32(52'(it_r[11].yd) - 52'(dy_r));
  end

  always_comb begin
    item_o = it_r[12];
    item_o.x = xo_r;
    item_o.y = yo_r;
  end

endmodule

### rtl/core/pixel_undistort_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_undistort_normalize
// A point passes the 31-step divide pipeline, then the twelve stages of each
// pass; one point per cycle.
// busy stays low, results are strobed once on out_valid; the receiver cannot stall.
// Synchronous reset clears the pipeline valid bits and loads default intrinsics.
// ----------------------------------------------------------------------------
module pixel_undistort_normalize
  import pun_pkg::*;
#(
  parameter int ITERATIONS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [23:0]        in_pixel_x,
  input  logic [23:0]        in_pixel_y,
  input  logic               in_last_point,
  output logic               out_valid,
  output logic signed [31:0] out_norm_x,
  output logic signed [31:0] out_norm_y,
  output logic               out_last_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [23:0]        focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic signed [31:0] k1_r, k2_r, p1_r, p2_r;
  pun_item_t          item [0:ITERATIONS];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= FOCAL_RST;
      focal_y_r <= FOCAL_RST;
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      k1_r <= '0;
      k2_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FOCAL_X:  focal_x_r <= cfg_data[23:0];
        REG_FOCAL_Y:  focal_y_r <= cfg_data[23:0];
        REG_CENTER_X: center_x_r <= cfg_data[23:0];
        REG_CENTER_Y: center_y_r <= cfg_data[23:0];
        REG_K1:       k1_r <= cfg_data;
        REG_K2:       k2_r <= cfg_data;
        REG_P1:       p1_r <= cfg_data;
        REG_P2:       p2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pun_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .pix_x    (in_pixel_x),
    .pix_y    (in_pixel_y),
    .last     (in_last_point),
    .focal_x  (focal_x_r),
    .focal_y  (focal_y_r),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .item_o   (item[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_pass
    pun_pass u_pass (
      .clk    (clk),
      .rst_n  (rst_n),
      .k1     (k1_r),
      .k2     (k2_r),
      .p1     (p1_r),
      .p2     (p2_r),
      .item_i (item[i]),
      .item_o (item[i+1])
    );
  end

  assign out_valid = item[ITERATIONS].vld;
  assign out_norm_x = item[ITERATIONS].x;
  assign out_norm_y = item[ITERATIONS].y;
  assign out_last_result = item[ITERATIONS].last;

endmodule
